// ===== src/tsi_pkg.sv =====
// Package for the timestamped sample interpolator.
// Types, codes and the controller/datapath interface structs.
// Depends on nothing.
package tsi_pkg;

    localparam int NUM_CH    = 6;
    localparam int TIME_W    = 63;
    localparam int CH_W      = 32;
    localparam int DIV_STEPS = 32;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_EXACT    = 3'd1,
        ST_INTERP   = 3'd2,
        ST_TOO_NEW  = 3'd3,
        ST_TOO_OLD  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_ROW,
        SRC_INTERP
    } t_src;

    typedef enum logic [1:0] {
        RS_NEWEST,
        RS_K,
        RS_KM1
    } t_rsel;

    typedef enum logic [2:0] {
        ALU_NONE,
        ALU_MUL0,
        ALU_MUL1,
        ALU_DINIT,
        ALU_DSTEP,
        ALU_DFIN
    } t_alu;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_PREAD, S_PCHK, S_PWR, S_SCAN, S_SCMP, S_RDI,
        S_RDJ, S_LATJ, S_MUL0, S_MUL1, S_DINIT, S_DIV, S_DFIN, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic [TIME_W-1:0]  time_ns;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_accel_x;
        logic signed [31:0] out_accel_y;
        logic signed [31:0] out_accel_z;
        logic signed [31:0] out_rate_x;
        logic signed [31:0] out_rate_y;
        logic signed [31:0] out_rate_z;
    } t_out;

    // one stored sample's channels, index 0 is accel_x
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_row;

    typedef struct packed {
        logic    load_in;
        t_rsel   rd_sel;
        logic    push_wr;
        logic    clear;
        logic    k_clr;
        logic    k_inc;
        logic    found;
        logic    lat_i;
        logic    lat_j;
        logic    ch_clr;
        logic    ch_inc;
        t_alu    alu_op;
        logic    out_load;
        t_status out_status;
        t_src    out_src;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic empty;
        logic t_lt_rd;
        logic t_eq_rd;
        logic k_zero;
        logic k_last;
        logic div_last;
        logic ch_last;
        logic out_free;
    } t_stat;

endpackage

// ===== src/tsi_ctrl.sv =====
// Controller state machine of the timestamped sample interpolator.
// Sequences push, search, row reads and the per-channel multiply/divide.
// Depends on tsi_pkg.
module tsi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tsi_pkg::t_stat i_stat,
    output tsi_pkg::t_cmd  o_cmd
);
    import tsi_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    t_src    r_src, n_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_ACCEPTED;
            r_src    <= SRC_ZERO;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_src    <= n_src;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_src    = r_src;
        o_cmd    = '0;
        o_cmd.rd_sel     = RS_K;
        o_cmd.alu_op     = ALU_NONE;
        o_cmd.out_status = r_status;
        o_cmd.out_src    = r_src;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.k_clr = 1'b1;
                n_status = ST_ACCEPTED;
                n_src    = SRC_ZERO;
                case (i_stat.op)
                    OP_PUSH: begin
                        n_state = i_stat.empty ? S_PWR : S_PREAD;
                    end
                    OP_QUERY: begin
                        if (i_stat.empty) begin
                            n_status = ST_TOO_NEW;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PREAD: begin
                o_cmd.rd_sel = RS_NEWEST;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_stat.t_lt_rd) begin
                    n_status = ST_TOO_OLD;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                o_cmd.push_wr = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                o_cmd.rd_sel = RS_K;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (i_stat.t_lt_rd || i_stat.t_eq_rd) begin
                    if (i_stat.t_eq_rd) begin
                        n_status = ST_EXACT;
                        n_src    = SRC_ROW;
                        n_state  = S_RDJ;
                    end else if (i_stat.k_zero) begin
                        n_status = ST_TOO_OLD;
                        n_state  = S_DONE;
                    end else begin
                        o_cmd.found = 1'b1;
                        n_status = ST_INTERP;
                        n_src    = SRC_INTERP;
                        n_state  = S_RDI;
                    end
                end else if (i_stat.k_last) begin
                    n_status = ST_TOO_NEW;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_RDI: begin
                o_cmd.rd_sel = RS_KM1;
                o_cmd.ch_clr = 1'b1;
                n_state = S_RDJ;
            end
            S_RDJ: begin
                o_cmd.rd_sel = RS_K;
                o_cmd.lat_i  = 1'b1;
                n_state = S_LATJ;
            end
            S_LATJ: begin
                o_cmd.lat_j = 1'b1;
                n_state = (r_status == ST_EXACT) ? S_DONE : S_MUL0;
            end
            S_MUL0: begin
                o_cmd.alu_op = ALU_MUL0;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.alu_op = ALU_MUL1;
                n_state = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.alu_op = ALU_DINIT;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.alu_op = ALU_DSTEP;
                if (i_stat.div_last) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.alu_op = ALU_DFIN;
                if (i_stat.ch_last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.ch_inc = 1'b1;
                    n_state = S_MUL0;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/tsi_dp.sv =====
// Datapath of the timestamped sample interpolator: sample ring memories,
// search registers, shared 32x32 and 32x31 multipliers, radix-2 divider, result register.
// Depends on tsi_pkg.
module tsi_dp #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsi_pkg::t_in   i_in_data,
    input  tsi_pkg::t_cmd  i_cmd,
    output tsi_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tsi_pkg::t_out  o_out_data
);
    import tsi_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [AW:0] DEPTH_W = (AW+1)'(BUFFER_DEPTH);

    logic [TIME_W-1:0] time_mem [BUFFER_DEPTH];
    t_row              row_mem  [BUFFER_DEPTH];

    t_in               r_in;
    logic [AW-1:0]     r_oldest;
    logic [AW:0]       r_count;
    logic [AW-1:0]     r_k;
    logic [TIME_W-1:0] r_prev, r_dt1, r_span, r_rd_time;
    t_row              r_rd_row, r_row_i, r_row_j, r_vals;
    logic [2:0]        r_ch;
    logic [31:0]       r_mag;
    logic              r_neg;
    logic [95:0]       r_acc;
    logic [64:0]       r_rem;
    logic [31:0]       r_quo;
    logic [4:0]        r_step;
    logic              r_out_valid;
    t_out              r_out;

    logic [AW-1:0] rd_idx, rd_slot, wr_slot;
    logic [AW:0]   rd_sum, wr_sum;
    t_row          in_row;

    always_comb begin
        case (i_cmd.rd_sel)
            RS_NEWEST: rd_idx = AW'(r_count - 1'b1);
            RS_KM1:    rd_idx = r_k - 1'b1;
            default:   rd_idx = r_k;
        endcase
    end

    // ring position: oldest + index, wrapped once
    assign rd_sum  = {1'b0, r_oldest} + {1'b0, rd_idx};
    assign rd_slot = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : rd_sum[AW-1:0];
    assign wr_sum  = {1'b0, r_oldest} + r_count;
    assign wr_slot = (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : wr_sum[AW-1:0];

    assign in_row = {r_in.rate_z, r_in.rate_y, r_in.rate_x,
                     r_in.accel_z, r_in.accel_y, r_in.accel_x};

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            time_mem[wr_slot] <= r_in.time_ns;
            row_mem[wr_slot]  <= in_row;
        end
        r_rd_time <= time_mem[rd_slot];
        r_rd_row  <= row_mem[rd_slot];
    end

    // ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
        end else if (i_cmd.clear) begin
            r_oldest <= '0;
            r_count  <= '0;
        end else if (i_cmd.push_wr) begin
            if (r_count == DEPTH_W) begin
                r_oldest <= (r_oldest == AW'(BUFFER_DEPTH - 1)) ? '0 : r_oldest + 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // channel arithmetic
    logic signed [31:0] ai, aj;
    logic signed [32:0] diff;
    logic [63:0]        prod_lo;
    logic [62:0]        prod_hi;
    logic [31:0]        mul_a;
    logic [96:0]        num;
    logic [65:0]        trial;
    logic [65:0]        dvsr;
    logic               ge;

    assign ai      = r_row_i[r_ch];
    assign aj      = r_row_j[r_ch];
    assign diff    = {aj[31], aj} - {ai[31], ai};
    assign mul_a   = r_mag;
    assign prod_lo = mul_a * r_dt1[31:0];
    assign prod_hi = mul_a * r_dt1[62:32];
    // round to nearest, ties up: bias by span, or span-1 for a negative step
    assign num     = {r_acc, 1'b0}
                     + {34'd0, (r_neg ? r_span - 1'b1 : r_span)};
    assign dvsr    = {2'b0, r_span, 1'b0};
    assign trial   = {r_rem, r_quo[31]};
    assign ge      = (trial >= dvsr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k    <= r_k + 1'b1;
            r_prev <= r_rd_time;
        end
        if (i_cmd.found) begin
            r_dt1  <= r_in.time_ns - r_prev;
            r_span <= r_rd_time - r_prev;
        end
        if (i_cmd.lat_i) begin
            r_row_i <= r_rd_row;
        end
        if (i_cmd.lat_j) begin
            r_row_j <= r_rd_row;
        end
        if (i_cmd.ch_clr) begin
            r_ch <= '0;
        end else if (i_cmd.ch_inc) begin
            r_ch <= r_ch + 1'b1;
        end
        case (i_cmd.alu_op)
            ALU_MUL0: begin
                r_neg <= diff[32];
                r_mag <= diff[32] ? 32'(-diff) : diff[31:0];
            end
            ALU_MUL1: begin
                r_acc <= {32'd0, prod_lo} + {1'b0, prod_hi, 32'd0};
            end
            ALU_DINIT: begin
                r_rem  <= num[96:32];
                r_quo  <= num[31:0];
                r_step <= '0;
            end
            ALU_DSTEP: begin
                r_rem  <= ge ? 65'(trial - dvsr) : trial[64:0];
                r_quo  <= {r_quo[30:0], ge};
                r_step <= r_step + 1'b1;
            end
            ALU_DFIN: begin
                r_vals[r_ch] <= r_neg ? ai - r_quo : ai + r_quo;
            end
            default: begin
            end
        endcase
    end

    // result register
    t_row out_row;
    always_comb begin
        case (i_cmd.out_src)
            SRC_ROW:    out_row = r_row_j;
            SRC_INTERP: out_row = r_vals;
            default:    out_row = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= i_cmd.out_status;
            r_out.out_accel_x <= out_row[0];
            r_out.out_accel_y <= out_row[1];
            r_out.out_accel_z <= out_row[2];
            r_out.out_rate_x  <= out_row[3];
            r_out.out_rate_y  <= out_row[4];
            r_out.out_rate_z  <= out_row[5];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.op       = t_op'(r_in.operation);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.t_lt_rd  = (r_in.time_ns < r_rd_time);
    assign o_stat.t_eq_rd  = (r_in.time_ns == r_rd_time);
    assign o_stat.k_zero   = (r_k == '0);
    assign o_stat.k_last   = (({1'b0, r_k} + 1'b1) == r_count);
    assign o_stat.div_last = (r_step == 5'(DIV_STEPS - 1));
    assign o_stat.ch_last  = (r_ch == 3'(NUM_CH - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_W)
        else $error("entry count above ring depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_wr && r_count == DEPTH_W) |=> (r_count == DEPTH_W))
        else $error("full ring lost an entry on push");

endmodule

// ===== src/timestamped_sample_interpolator.sv =====
// Top level of the timestamped sample interpolator.
// Joins the controller (tsi_ctrl) and the datapath (tsi_dp); uses tsi_pkg.
//
// Input channel i_in_valid/o_in_ready/i_in_data carries one item: a push, a
// query, a clear or a no-op. Every item yields exactly one result item on
// o_out_valid/i_out_ready/o_out_data.
// One item is worked on at a time; o_in_ready is high while the controller idles.
// Work per item, set by the single-port ring scan and the shared divider:
//   clear / no-op: result only; push: written at once into an empty ring, else
//   the newest time is read first and a stale push refused; query: entries
//   compared one by one from the oldest, then too_new / too_old, an exact
//   match, or interpolation (per channel: a 32x32 and a 32x31 partial product,
//   a rounding add and a 32-step restoring divide). An empty-ring query is too_new.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls with a result already held, the block
// finishes its current item and then waits until the register frees up.
// Reset empties the ring; stored samples are not cleared, only the count.
module timestamped_sample_interpolator #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tsi_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tsi_pkg::t_out o_out_data
);
    import tsi_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tsi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tsi_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
